FILE: design/tclru_pkg.sv
// Shared types and constants for the tile cache LRU request policy block.
`timescale 1ns / 1ps

package tclru_pkg;

    // Field widths fixed by the request and result formats.
    localparam int FUNC_W   = 2;
    localparam int IN_TAG_W = 16;
    localparam int IDX_W    = 2;
    localparam int STATUS_W = 3;
    localparam int WHICH_W  = 2;
    localparam int STAMP_W  = 32;

    // Request function codes.
    localparam logic [FUNC_W-1:0] FN_LOOKUP    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_DONE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_TOUCH     = 2'd2;

    typedef enum logic [1:0] {
        ST_UNUSED    = 2'd0,
        ST_REQUESTED = 2'd1,
        ST_LOADED    = 2'd2
    } t_entry_state;

    typedef enum logic [STATUS_W-1:0] {
        RS_HIT_LOADED  = 3'd0,
        RS_HIT_PENDING = 3'd1,
        RS_MISS_REQ    = 3'd2,
        RS_MISS_BUSY   = 3'd3,
        RS_ACK         = 3'd4
    } t_status;

    typedef logic [WHICH_W-1:0] t_which;

    // Controller to datapath.
    typedef struct packed {
        logic start;    // request accepted: latch it, clear the scan
        logic scan_rd;  // read the next entry of the tag and stamp memories
        logic commit;   // apply the update and load the result register
    } t_ctrl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic in_lookup; // request on the input is a lookup
        logic rd_last;   // the read issued now is of the last entry
        logic out_busy;  // result register full and not being taken
    } t_dp_status;

endpackage

FILE: design/tclru_ctrl.sv
// Sequencing state machine for the tile cache LRU request policy block.
`timescale 1ns / 1ps

module tclru_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tclru_pkg::t_dp_status i_sts,
    output tclru_pkg::t_ctrl_cmd  o_cmd
);
    import tclru_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   accept;

    assign accept     = i_in_valid & r_in_ready;
    assign o_in_ready = r_in_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.start   = accept;
        o_cmd.scan_rd = (r_state == S_SCAN);
        o_cmd.commit  = (r_state == S_DONE) && !i_sts.out_busy;
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_sts.in_lookup ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (i_sts.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

endmodule

FILE: design/tclru_datapath.sv
// Entry store, scan accumulators, update logic and result register.
`timescale 1ns / 1ps

module tclru_datapath #(
    parameter int NUM_ENTRIES = 4,
    parameter int TAG_BITS    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tclru_pkg::t_ctrl_cmd              i_cmd,
    output tclru_pkg::t_dp_status             o_sts,
    input  logic [tclru_pkg::FUNC_W-1:0]      i_func,
    input  logic [tclru_pkg::IN_TAG_W-1:0]    i_lat_tag,
    input  logic [tclru_pkg::IN_TAG_W-1:0]    i_lon_tag,
    input  logic [tclru_pkg::IDX_W-1:0]       i_entry_index,
    input  logic                              i_load_ok,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [tclru_pkg::STATUS_W-1:0]    o_status,
    output logic [tclru_pkg::WHICH_W-1:0]     o_hit_or_victim
);
    import tclru_pkg::*;

    localparam int AW = $clog2(NUM_ENTRIES);

    // Entry state: flip-flops, cleared by reset.
    t_entry_state r_entry_state [NUM_ENTRIES];
    // Tag pair and stamp stores: no reset, an unused entry is never trusted.
    logic [2*TAG_BITS-1:0] r_tag_mem   [NUM_ENTRIES];
    logic [STAMP_W-1:0]    r_stamp_mem [NUM_ENTRIES];

    // Latched request.
    logic [FUNC_W-1:0]     r_func;
    logic [TAG_BITS-1:0]   r_lat;
    logic [TAG_BITS-1:0]   r_lon;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_ok;

    // Scan read port and accumulators.
    logic [AW-1:0]         r_rd_addr;
    logic [AW-1:0]         r_rd_idx;
    logic                  r_rd_pend;
    logic [2*TAG_BITS-1:0] r_rd_tag;
    logic [STAMP_W-1:0]    r_rd_stamp;
    logic                  r_found;
    logic [AW-1:0]         r_hit;
    logic                  r_have_v;
    logic [AW-1:0]         r_victim;
    logic [STAMP_W-1:0]    r_low;

    logic [STAMP_W-1:0]    r_tick;

    logic                  r_out_valid;
    t_status               r_status;
    t_which                r_which;

    // Scan evaluation of the entry whose read data is now registered.
    t_entry_state          e_state;
    logic [STAMP_W-1:0]    e_stamp;
    logic                  e_hit;
    logic                  e_cand;

    // Commit decode.
    logic [AW-1:0]         ev_entry;
    t_entry_state          ev_state;
    logic                  idx_ok;
    logic                  do_alloc;
    logic                  do_load;
    logic                  do_touch;
    t_status               n_status;
    t_which                n_which;

    assign o_sts.in_lookup = (i_func == FN_LOOKUP);
    assign o_sts.rd_last   = (r_rd_addr == AW'(NUM_ENTRIES - 1));
    assign o_sts.out_busy  = r_out_valid & ~i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_hit_or_victim = r_which;

    always_comb begin
        e_state = r_entry_state[r_rd_idx];
        e_stamp = (e_state == ST_UNUSED) ? '0 : r_rd_stamp;
        e_hit   = (e_state != ST_UNUSED) && (r_rd_tag == {r_lat, r_lon});
        e_cand  = (e_state != ST_REQUESTED) && (!r_have_v || (e_stamp < r_low));
    end

    always_comb begin
        idx_ok   = (int'(r_idx) < NUM_ENTRIES);
        ev_entry = AW'(r_idx);
        ev_state = r_entry_state[ev_entry];
        do_alloc = 1'b0;
        do_load  = 1'b0;
        do_touch = 1'b0;
        n_status = RS_ACK;
        n_which  = '0;
        case (r_func)
            FN_LOOKUP: begin
                if (r_found) begin
                    n_status = (r_entry_state[r_hit] == ST_LOADED) ? RS_HIT_LOADED
                                                                   : RS_HIT_PENDING;
                    n_which  = t_which'(r_hit);
                end else if (r_have_v) begin
                    do_alloc = 1'b1;
                    n_status = RS_MISS_REQ;
                    n_which  = t_which'(r_victim);
                end else begin
                    n_status = RS_MISS_BUSY;
                end
            end
            FN_LOAD_DONE: begin
                do_load = idx_ok && (ev_state == ST_REQUESTED);
            end
            FN_TOUCH: begin
                do_touch = idx_ok && (ev_state == ST_LOADED);
            end
            default: begin
                n_status = RS_ACK;
            end
        endcase
    end

    // Tag store: one write, one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_alloc) begin
            r_tag_mem[r_victim] <= {r_lat, r_lon};
        end
        if (i_cmd.scan_rd) begin
            r_rd_tag <= r_tag_mem[r_rd_addr];
        end
    end

    // Stamp store: a failed load leaves the entry unused with stamp zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (do_load || do_touch)) begin
            r_stamp_mem[ev_entry] <= (do_load && !r_ok) ? '0 : r_tick;
        end
        if (i_cmd.scan_rd) begin
            r_rd_stamp <= r_stamp_mem[r_rd_addr];
        end
    end

    // Request latch and scan accumulators.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func <= i_func;
            r_lat  <= TAG_BITS'(i_lat_tag);
            r_lon  <= TAG_BITS'(i_lon_tag);
            r_idx  <= i_entry_index;
            r_ok   <= i_load_ok;
        end
        if (i_cmd.scan_rd) begin
            r_rd_idx <= r_rd_addr;
        end
        if (r_rd_pend) begin
            if (e_hit) begin
                r_hit <= r_rd_idx;
            end
            if (e_cand) begin
                r_victim <= r_rd_idx;
                r_low    <= e_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_entry_state[i] <= ST_UNUSED;
            end
            r_rd_addr   <= '0;
            r_rd_pend   <= 1'b0;
            r_found     <= 1'b0;
            r_have_v    <= 1'b0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
            r_status    <= RS_ACK;
            r_which     <= '0;
        end else begin
            r_rd_pend <= i_cmd.scan_rd;
            if (i_cmd.start) begin
                r_rd_addr <= '0;
                r_found   <= 1'b0;
                r_have_v  <= 1'b0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_rd_addr <= r_rd_addr + 1'b1;
                end
                if (r_rd_pend) begin
                    if (e_hit) begin
                        r_found <= 1'b1;
                    end
                    if (e_cand) begin
                        r_have_v <= 1'b1;
                    end
                end
            end

            if (i_cmd.commit) begin
                if (do_alloc) begin
                    r_entry_state[r_victim] <= ST_REQUESTED;
                end
                if (do_load) begin
                    r_entry_state[ev_entry] <= r_ok ? ST_LOADED : ST_UNUSED;
                end
                if (do_load || do_touch) begin
                    r_tick <= r_tick + 1'b1;
                end
                r_out_valid <= 1'b1;
                r_status    <= n_status;
                r_which     <= n_which;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: design/tile_cache_lru_request_policy.sv
// Top level of the tile cache LRU request policy block.
`timescale 1ns / 1ps

// Fully associative tile tag cache with least-recently-used replacement.
// Each request is a lookup of a latitude/longitude tag pair, a load-finished
// event or a touch event, and produces exactly one result. A lookup walks
// the entries one per cycle through the single read port of the tag and
// stamp stores and then passes a drain state and a commit state; the next
// request is taken only after the commit. Load-finished and touch events
// need no scan and go straight to the commit state. The result sits in an
// output register, so a new request is accepted while the previous result
// still waits on m_axis_tready; the block only stalls when it has a second
// result ready and the first has not yet been taken. On a lookup the last
// matching valid entry wins; on a miss the non-requested entry with the
// lowest stamp (lowest index on a tie) takes the tags and becomes requested.
// Stamps come from a 32-bit wrapping tick that advances on every applied
// load-finished or touch event. Reset clears entry state; no clearing pass
// is needed, since unused entries are never matched and read as stamp zero.
module tile_cache_lru_request_policy #(
    parameter int NUM_ENTRIES = 4,
    parameter int TAG_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // lat_tag[15:0], lon_tag[31:16],
                                       // entry_index[33:32], load_ok[34], zero
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    // Result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // hit_or_victim[1:0], zero
    output logic [2:0]  m_axis_tuser   // status[2:0]
);
    import tclru_pkg::*;

    t_ctrl_cmd                cmd;
    t_dp_status               sts;
    logic [WHICH_W-1:0]       hit_or_victim;

    // Sequence each request: accept, scan (lookups only), commit.
    tclru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold the entries, evaluate the scan, apply updates and hold the result.
    tclru_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .TAG_BITS    (TAG_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_func          (s_axis_tuser[FUNC_W-1:0]),
        .i_lat_tag       (s_axis_tdata[15:0]),
        .i_lon_tag       (s_axis_tdata[31:16]),
        .i_entry_index   (s_axis_tdata[33:32]),
        .i_load_ok       (s_axis_tdata[34]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_status        (m_axis_tuser),
        .o_hit_or_victim (hit_or_victim)
    );

    // Pad the result entry number to a whole byte.
    assign m_axis_tdata = {6'b0, hit_or_victim};

endmodule

FILE: design/tclru_checker.sv
// Port-level checks for the tile cache LRU request policy block.
`timescale 1ns / 1ps

module tclru_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import tclru_pkg::*;

    // A request is worked on alone: ready drops after acceptance.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while a previous request is in progress");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Only five status codes exist.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= RS_ACK))
        else $error("result status out of range");

    // Acknowledge and all-busy carry no entry number.
    a_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == RS_ACK || m_axis_tuser == RS_MISS_BUSY)
            |-> (m_axis_tdata == 8'd0))
        else $error("entry number present on a result that has none");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind tile_cache_lru_request_policy tclru_checker u_tclru_checker (.*);
